// ===== design/refbp_pkg.sv =====
// ----------------------------------------------------------------------------
// refbp_pkg
// Shared types and constants for the reference-counted buffer pool: operation
// and status codes, controller states and the controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none

package refbp_pkg;

    // Fixed widths of the request and result fields.
    localparam int OP_W      = 3;
    localparam int IDX_W     = 10;
    localparam int CHAN_IN_W = 8;
    localparam int STATUS_W  = 3;
    localparam int REL_CNT_W = 11;

    // Default pool configuration.
    localparam int DEF_NUM_SLOTS    = 1024;
    localparam int DEF_CHANNEL_BITS = 8;
    localparam int DEF_COUNT_BITS   = 16;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 3'd0,
        OP_FREE  = 3'd1,
        OP_GET   = 3'd2,
        OP_PUT   = 3'd3,
        OP_CLEAR = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK            = 3'd0,
        STAT_OUT_OF_BUFS   = 3'd1,
        STAT_COUNT_ZERO    = 3'd2,
        STAT_NOT_ALLOCATED = 3'd3,
        STAT_OVERFLOW      = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_EXEC  = 2'd1,
        S_SWEEP = 2'd2
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // request transfer: capture fields, issue slot read
        logic exec;    // apply a single-slot operation and load the result
        logic scan;    // advance the clear-channel sweep by one slot
        logic finish;  // load the clear-channel result
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_req;  // the offered request is a clear-channel
        logic scan_done;  // sweep has read and evaluated every touched slot
        logic out_free;   // result register can take a new result this cycle
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== design/refbp_ctrl.sv =====
// ----------------------------------------------------------------------------
// refbp_ctrl
// Controller for the buffer pool: sequences request capture, single-slot
// execution and the clear-channel sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module refbp_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  refbp_pkg::t_dp_stat  i_stat,
    output refbp_pkg::t_dp_cmd   o_cmd
);

    refbp_pkg::t_state r_state;
    refbp_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= refbp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            refbp_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_stat.clear_req ? refbp_pkg::S_SWEEP : refbp_pkg::S_EXEC;
                end
            end
            refbp_pkg::S_EXEC: begin
                if (i_stat.out_free) begin
                    n_state = refbp_pkg::S_IDLE;
                end
            end
            refbp_pkg::S_SWEEP: begin
                if (i_stat.scan_done && i_stat.out_free) begin
                    n_state = refbp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = refbp_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        case (r_state)
            refbp_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            refbp_pkg::S_EXEC: begin
                o_cmd.exec = i_stat.out_free;
            end
            refbp_pkg::S_SWEEP: begin
                o_cmd.scan   = 1'b1;
                o_cmd.finish = i_stat.scan_done && i_stat.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/refbp_dp.sv =====
// ----------------------------------------------------------------------------
// refbp_dp
// Datapath for the buffer pool: slot memories, free-list head, fill mark,
// request registers, sweep counters and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module refbp_dp #(
    parameter int NUM_SLOTS    = refbp_pkg::DEF_NUM_SLOTS,
    parameter int CHANNEL_BITS = refbp_pkg::DEF_CHANNEL_BITS,
    parameter int COUNT_BITS   = refbp_pkg::DEF_COUNT_BITS
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire  [refbp_pkg::OP_W-1:0]        i_operation,
    input  wire  [refbp_pkg::IDX_W-1:0]       i_slot_index,
    input  wire  [refbp_pkg::CHAN_IN_W-1:0]   i_owner_channel,
    input  wire                               i_out_ready,
    input  refbp_pkg::t_dp_cmd                i_cmd,
    output refbp_pkg::t_dp_stat               o_stat,
    output logic                              o_out_valid,
    output logic [refbp_pkg::STATUS_W-1:0]    o_status,
    output logic [refbp_pkg::IDX_W-1:0]       o_granted_slot,
    output logic                              o_slot_released,
    output logic [refbp_pkg::REL_CNT_W-1:0]   o_released_count
);

    localparam int SLOT_BITS = $clog2(NUM_SLOTS);
    localparam int PTR_BITS  = SLOT_BITS + 1;
    localparam logic [PTR_BITS-1:0] PTR_EMPTY = PTR_BITS'(NUM_SLOTS);

    // Slot memories, one entry per slot, sharing one address per port.
    logic                    mem_used  [NUM_SLOTS];
    logic [PTR_BITS-1:0]     mem_link  [NUM_SLOTS];
    logic [COUNT_BITS-1:0]   mem_count [NUM_SLOTS];
    logic [CHANNEL_BITS-1:0] mem_owner [NUM_SLOTS];

    logic                    r_q_used;
    logic [PTR_BITS-1:0]     r_q_link;
    logic [COUNT_BITS-1:0]   r_q_count;
    logic [CHANNEL_BITS-1:0] r_q_owner;

    // Request registers.
    logic [refbp_pkg::OP_W-1:0]  r_op;
    logic [refbp_pkg::IDX_W-1:0] r_idx;
    logic [CHANNEL_BITS-1:0]     r_chan;
    logic                        r_in_range;
    logic [SLOT_BITS-1:0]        r_addr;
    logic                        r_seen;

    // Free list and fill mark. Slots at or above the fill mark were never
    // handed out, so their link is their index plus one and they are free.
    logic [PTR_BITS-1:0] r_head;
    logic [PTR_BITS-1:0] r_fill;

    // Sweep state.
    logic [PTR_BITS-1:0]  r_scan;
    logic                 r_scan_vld;
    logic [SLOT_BITS-1:0] r_eval_addr;
    logic [PTR_BITS-1:0]  r_swept;

    // Result register.
    logic                              r_out_valid;
    logic [refbp_pkg::STATUS_W-1:0]    r_status;
    logic [refbp_pkg::IDX_W-1:0]       r_granted;
    logic                              r_released;
    logic [refbp_pkg::REL_CNT_W-1:0]   r_rel_count;

    logic                 rd_en;
    logic [SLOT_BITS-1:0] rd_addr;
    logic                 scan_more;
    logic                 out_free;

    logic                 d_used;
    logic [PTR_BITS-1:0]  d_link;
    logic                 head_empty;
    logic                 cnt_zero;
    logic                 cnt_max;

    logic [refbp_pkg::STATUS_W-1:0] ex_status;
    logic [refbp_pkg::IDX_W-1:0]    ex_granted;
    logic                           ex_released;
    logic                           ex_we;
    logic                           ex_head_we;
    logic [PTR_BITS-1:0]            ex_head;
    logic                           ex_fill_inc;
    logic                           ex_used;
    logic [PTR_BITS-1:0]            ex_link;
    logic [COUNT_BITS-1:0]          ex_count;
    logic [CHANNEL_BITS-1:0]        ex_owner;

    logic                    sw_hit;
    logic                    mem_we;
    logic [SLOT_BITS-1:0]    wr_addr;
    logic                    wr_used;
    logic [PTR_BITS-1:0]     wr_link;
    logic [COUNT_BITS-1:0]   wr_count;
    logic [CHANNEL_BITS-1:0] wr_owner;

    assign scan_more = (r_scan < r_fill);
    assign out_free  = !r_out_valid || i_out_ready;

    assign o_stat.clear_req = (i_operation == refbp_pkg::OP_CLEAR);
    assign o_stat.scan_done = !r_scan_vld && !scan_more;
    assign o_stat.out_free  = out_free;

    // Read port address: list head for alloc, request slot otherwise, or the
    // sweep pointer.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_scan[SLOT_BITS-1:0];
        if (i_cmd.load) begin
            rd_en   = 1'b1;
            rd_addr = (i_operation == refbp_pkg::OP_ALLOC) ? r_head[SLOT_BITS-1:0]
                                                           : SLOT_BITS'(i_slot_index);
        end else if (i_cmd.scan && scan_more) begin
            rd_en = 1'b1;
        end
    end

    assign d_used     = r_seen && r_q_used;
    assign d_link     = r_seen ? r_q_link : (PTR_BITS'(r_addr) + PTR_BITS'(1));
    assign head_empty = (r_head == PTR_EMPTY);
    assign cnt_zero   = (r_q_count == '0);
    assign cnt_max    = (r_q_count == '1);

    // Single-slot operation.
    always_comb begin
        ex_status   = refbp_pkg::STAT_OK;
        ex_granted  = r_idx;
        ex_released = 1'b0;
        ex_we       = 1'b0;
        ex_head_we  = 1'b0;
        ex_head     = PTR_BITS'(r_addr);
        ex_fill_inc = 1'b0;
        ex_used     = r_q_used;
        ex_link     = r_q_link;
        ex_count    = r_q_count;
        ex_owner    = r_q_owner;
        case (r_op)
            refbp_pkg::OP_ALLOC: begin
                if (head_empty) begin
                    ex_status = refbp_pkg::STAT_OUT_OF_BUFS;
                end else begin
                    ex_we       = 1'b1;
                    ex_used     = 1'b1;
                    ex_link     = d_link;
                    ex_count    = COUNT_BITS'(1);
                    ex_owner    = r_chan;
                    ex_head_we  = 1'b1;
                    ex_head     = d_link;
                    ex_fill_inc = !r_seen;
                    ex_granted  = refbp_pkg::IDX_W'(r_addr);
                end
            end
            refbp_pkg::OP_FREE: begin
                if (!r_in_range || !d_used) begin
                    ex_status = refbp_pkg::STAT_NOT_ALLOCATED;
                end else begin
                    ex_we       = 1'b1;
                    ex_used     = 1'b0;
                    ex_link     = r_head;
                    ex_head_we  = 1'b1;
                    ex_released = 1'b1;
                end
            end
            refbp_pkg::OP_GET: begin
                if (!r_in_range) begin
                    ex_status = refbp_pkg::STAT_NOT_ALLOCATED;
                end else if (!d_used || cnt_zero) begin
                    ex_status = refbp_pkg::STAT_COUNT_ZERO;
                end else if (cnt_max) begin
                    ex_status = refbp_pkg::STAT_OVERFLOW;
                end else begin
                    ex_we    = 1'b1;
                    ex_count = r_q_count + COUNT_BITS'(1);
                end
            end
            refbp_pkg::OP_PUT: begin
                if (!r_in_range) begin
                    ex_status = refbp_pkg::STAT_NOT_ALLOCATED;
                end else if (!d_used || cnt_zero) begin
                    ex_status = refbp_pkg::STAT_COUNT_ZERO;
                end else begin
                    ex_we    = 1'b1;
                    ex_count = r_q_count - COUNT_BITS'(1);
                    if (r_q_count == COUNT_BITS'(1)) begin
                        ex_used     = 1'b0;
                        ex_link     = r_head;
                        ex_head_we  = 1'b1;
                        ex_released = 1'b1;
                    end
                end
            end
            default: begin
                ex_status = refbp_pkg::STAT_NOT_ALLOCATED;
            end
        endcase
    end

    // Sweep: every scanned slot lies below the fill mark, so its read data
    // is valid.
    assign sw_hit = r_scan_vld && r_q_used && (r_q_owner == r_chan);

    always_comb begin
        mem_we   = 1'b0;
        wr_addr  = r_eval_addr;
        wr_used  = 1'b0;
        wr_link  = r_head;
        wr_count = r_q_count;
        wr_owner = r_q_owner;
        if (i_cmd.exec) begin
            mem_we   = ex_we;
            wr_addr  = r_addr;
            wr_used  = ex_used;
            wr_link  = ex_link;
            wr_count = ex_count;
            wr_owner = ex_owner;
        end else if (i_cmd.scan) begin
            mem_we = sw_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_used[wr_addr]  <= wr_used;
            mem_link[wr_addr]  <= wr_link;
            mem_count[wr_addr] <= wr_count;
            mem_owner[wr_addr] <= wr_owner;
        end
        if (rd_en) begin
            r_q_used  <= mem_used[rd_addr];
            r_q_link  <= mem_link[rd_addr];
            r_q_count <= mem_count[rd_addr];
            r_q_owner <= mem_owner[rd_addr];
        end
    end

    // Request capture and sweep pointer.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= i_operation;
            r_idx      <= i_slot_index;
            r_chan     <= CHANNEL_BITS'(i_owner_channel);
            r_in_range <= ({22'd0, i_slot_index} < 32'(NUM_SLOTS));
            r_addr     <= rd_addr;
            r_seen     <= (PTR_BITS'(rd_addr) < r_fill);
            r_scan     <= '0;
            r_swept    <= '0;
        end else if (i_cmd.scan) begin
            if (scan_more) begin
                r_scan      <= r_scan + PTR_BITS'(1);
                r_eval_addr <= r_scan[SLOT_BITS-1:0];
            end
            if (sw_hit) begin
                r_swept <= r_swept + PTR_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_fill      <= '0;
            r_scan_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec && ex_head_we) begin
                r_head <= ex_head;
            end else if (i_cmd.scan && sw_hit) begin
                r_head <= PTR_BITS'(r_eval_addr);
            end
            if (i_cmd.exec && ex_fill_inc) begin
                r_fill <= r_fill + PTR_BITS'(1);
            end
            if (i_cmd.load) begin
                r_scan_vld <= 1'b0;
            end else if (i_cmd.scan) begin
                r_scan_vld <= scan_more;
            end
            if (i_cmd.exec || i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status    <= ex_status;
            r_granted   <= ex_granted;
            r_released  <= ex_released;
            r_rel_count <= '0;
        end else if (i_cmd.finish) begin
            r_status    <= refbp_pkg::STAT_OK;
            r_granted   <= r_idx;
            r_released  <= 1'b0;
            r_rel_count <= refbp_pkg::REL_CNT_W'(r_swept);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_granted_slot   = r_granted;
    assign o_slot_released  = r_released;
    assign o_released_count = r_rel_count;

endmodule

`default_nettype wire

// ===== design/refcounted_buffer_pool.sv =====
// ----------------------------------------------------------------------------
// refcounted_buffer_pool
// Reference-counted pool of fixed buffer slots on a last-in-first-out free
// list, with alloc, free, get, put and clear-channel requests.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the input channel (i_in_valid / o_in_ready) carrying
// i_operation, i_slot_index and i_owner_channel. Each request produces exactly
// one result on the output channel (o_out_valid / i_out_ready) carrying
// o_status, o_granted_slot, o_slot_released and o_released_count.
// The pool works on one request at a time. Alloc, free, get and put are a
// read-modify-write of one slot entry: the transfer cycle issues the read and
// the EXEC state, once the result register is free, writes the slot and loads
// the result register.
// Clear channel streams through every slot ever handed out, one slot per cycle
// (at most NUM_SLOTS); the registered read of the slot memories puts each
// slot's evaluation one register behind its read.
// Reset clears the free list to its initial order (slot 0 at the head) at
// once by means of a fill mark, so there is no clearing pass; requests are
// accepted as soon as reset is released.
// The result register sits between the request side and the receiver: a new
// request is accepted while an earlier result waits. If the receiver stalls,
// the next result is held back and the pool waits before committing it.
// ----------------------------------------------------------------------------
`default_nettype none

module refcounted_buffer_pool #(
    parameter int NUM_SLOTS    = refbp_pkg::DEF_NUM_SLOTS,
    parameter int CHANNEL_BITS = refbp_pkg::DEF_CHANNEL_BITS,
    parameter int COUNT_BITS   = refbp_pkg::DEF_COUNT_BITS
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  wire  [refbp_pkg::OP_W-1:0]        i_operation,
    input  wire  [refbp_pkg::IDX_W-1:0]       i_slot_index,
    input  wire  [refbp_pkg::CHAN_IN_W-1:0]   i_owner_channel,
    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output logic [refbp_pkg::STATUS_W-1:0]    o_status,
    output logic [refbp_pkg::IDX_W-1:0]       o_granted_slot,
    output logic                              o_slot_released,
    output logic [refbp_pkg::REL_CNT_W-1:0]   o_released_count
);

    // Command and status between the controller and the datapath.
    refbp_pkg::t_dp_cmd  dp_cmd;
    refbp_pkg::t_dp_stat dp_stat;

    // The controller only sequences; it never sees payload.
    refbp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // The datapath holds the slot memories, the free-list head and the
    // result register.
    refbp_dp #(
        .NUM_SLOTS    (NUM_SLOTS),
        .CHANNEL_BITS (CHANNEL_BITS),
        .COUNT_BITS   (COUNT_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_operation      (i_operation),
        .i_slot_index     (i_slot_index),
        .i_owner_channel  (i_owner_channel),
        .i_out_ready      (i_out_ready),
        .i_cmd            (dp_cmd),
        .o_stat           (dp_stat),
        .o_out_valid      (o_out_valid),
        .o_status         (o_status),
        .o_granted_slot   (o_granted_slot),
        .o_slot_released  (o_slot_released),
        .o_released_count (o_released_count)
    );

endmodule

`default_nettype wire

// ===== design/refbp_chk.sv =====
// ----------------------------------------------------------------------------
// refbp_chk
// Port-level checks for the buffer pool, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module refbp_chk (
    input wire                               i_clk,
    input wire                               i_rst_n,
    input wire                               i_in_valid,
    input wire                               o_in_ready,
    input wire                               o_out_valid,
    input wire                               i_out_ready,
    input wire [refbp_pkg::STATUS_W-1:0]     o_status,
    input wire [refbp_pkg::IDX_W-1:0]        o_granted_slot,
    input wire                               o_slot_released,
    input wire [refbp_pkg::REL_CNT_W-1:0]    o_released_count
);

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_status) && $stable(o_granted_slot) &&
            $stable(o_slot_released) && $stable(o_released_count))
        else $error("result changed while stalled");

    // One request is in work at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request accepted while another is in work");

    // Slots are only returned by successful operations.
    a_release_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_slot_released |->
            o_status == refbp_pkg::STAT_OK && o_released_count == '0)
        else $error("slot released with error status or sweep count");

    a_sweep_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_released_count != '0 |->
            o_status == refbp_pkg::STAT_OK && !o_slot_released)
        else $error("sweep count with error status");

endmodule

bind refcounted_buffer_pool refbp_chk u_refbp_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_status         (o_status),
    .o_granted_slot   (o_granted_slot),
    .o_slot_released  (o_slot_released),
    .o_released_count (o_released_count)
);

`default_nettype wire

// ===== tb/tb_refcounted_buffer_pool.sv =====
// ----------------------------------------------------------------------------
// tb_refcounted_buffer_pool
// Self-checking testbench for the reference-counted buffer pool. A behavioral
// copy of the free list, counts and owners predicts each result. The stimulus
// runs through a directed table, then drains the pool, and then sends random
// requests. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb_refcounted_buffer_pool;

    localparam int POOL_SLOTS      = refbp_pkg::DEF_NUM_SLOTS;
    localparam int REF_BITS        = refbp_pkg::DEF_COUNT_BITS;
    localparam int CHAN_BITS       = refbp_pkg::DEF_CHANNEL_BITS;
    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 11;
    localparam int RANDOM_ITEMS    = 200;
    localparam int QUIET_ITEMS     = 60;
    localparam int HOLD_OFF_AFTER  = 100;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 16;
    localparam int CYCLE_LIMIT     = 6_000_000;
    localparam int MAX_REPORTS     = 100;

    localparam logic [REF_BITS-1:0] REF_MAX = '1;

    // Operation codes that the pool does not define; it answers them with
    // a not-allocated status.
    localparam logic [refbp_pkg::OP_W-1:0] OP_RESERVED_FIRST = 3'd5;
    localparam logic [refbp_pkg::OP_W-1:0] OP_RESERVED_LAST  = 3'd7;

    typedef struct packed {
        logic [refbp_pkg::STATUS_W-1:0]  status;
        logic [refbp_pkg::IDX_W-1:0]     slot;
        logic                            released;
        logic [refbp_pkg::REL_CNT_W-1:0] swept;
    } t_pool_result;

    typedef struct packed {
        logic [refbp_pkg::OP_W-1:0]      op;
        logic [refbp_pkg::IDX_W-1:0]     idx;
        logic [refbp_pkg::CHAN_IN_W-1:0] chan;
        logic                            typed;
        t_pool_result                    want;
    } t_directed_row;

    logic                             i_clk           = 1'b0;
    logic                             i_rst_n         = 1'b0;
    logic                             i_in_valid      = 1'b0;
    logic [refbp_pkg::OP_W-1:0]       i_operation     = refbp_pkg::OP_ALLOC;
    logic [refbp_pkg::IDX_W-1:0]      i_slot_index    = '0;
    logic [refbp_pkg::CHAN_IN_W-1:0]  i_owner_channel = '0;
    logic                             i_out_ready     = 1'b0;
    wire                              o_in_ready;
    wire                              o_out_valid;
    wire  [refbp_pkg::STATUS_W-1:0]   o_status;
    wire  [refbp_pkg::IDX_W-1:0]      o_granted_slot;
    wire                              o_slot_released;
    wire  [refbp_pkg::REL_CNT_W-1:0]  o_released_count;

    // Predicted pool state: list head and links (POOL_SLOTS marks the end of
    // the list), in-use flags, reference counts and owner channels.
    logic [refbp_pkg::IDX_W:0]   free_head;
    logic [refbp_pkg::IDX_W:0]   free_link [POOL_SLOTS];
    logic                        slot_busy [POOL_SLOTS];
    logic [REF_BITS-1:0]         slot_refs [POOL_SLOTS];
    logic [CHAN_BITS-1:0]        slot_chan [POOL_SLOTS];

    t_pool_result  pending_results [$];
    t_directed_row directed_plan [$];

    int fail_count   = 0;
    int results_seen = 0;
    int cycle_count  = 0;
    int hold_left    = 0;
    int stall_left   = 0;
    bit hold_done    = 1'b0;
    bit quiet        = 1'b0;

    refcounted_buffer_pool i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_slot_index     (i_slot_index),
        .i_owner_channel  (i_owner_channel),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_granted_slot   (o_granted_slot),
        .o_slot_released  (o_slot_released),
        .o_released_count (o_released_count)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Returning a slot always pushes it on the head of the free list. The
    // count and owner are left alone; the next alloc rewrites them.
    function automatic void release_slot(int s);
        slot_busy[s] = 1'b0;
        free_link[s] = free_head;
        free_head    = (refbp_pkg::IDX_W+1)'(s);
    endfunction

    // Applies one request to the predicted state and returns its result.
    function automatic t_pool_result pool_step(logic [refbp_pkg::OP_W-1:0] op,
                                               logic [refbp_pkg::IDX_W-1:0] idx,
                                               logic [refbp_pkg::CHAN_IN_W-1:0] chan_in);
        t_pool_result         res;
        logic [CHAN_BITS-1:0] chan;
        int                   s;
        res        = '0;
        res.status = refbp_pkg::STAT_OK;
        res.slot   = idx;
        chan       = chan_in[CHAN_BITS-1:0];
        case (op)
            refbp_pkg::OP_ALLOC: begin
                if (free_head >= POOL_SLOTS) begin
                    res.status = refbp_pkg::STAT_OUT_OF_BUFS;
                end else begin
                    s            = int'(free_head);
                    free_head    = free_link[s];
                    slot_busy[s] = 1'b1;
                    slot_chan[s] = chan;
                    slot_refs[s] = REF_BITS'(1);
                    res.slot     = refbp_pkg::IDX_W'(s);
                end
            end
            refbp_pkg::OP_FREE: begin
                if (!slot_busy[idx]) begin
                    res.status = refbp_pkg::STAT_NOT_ALLOCATED;
                end else begin
                    release_slot(int'(idx));
                    res.released = 1'b1;
                end
            end
            refbp_pkg::OP_GET: begin
                if (!slot_busy[idx] || slot_refs[idx] == 0) begin
                    res.status = refbp_pkg::STAT_COUNT_ZERO;
                end else if (slot_refs[idx] == REF_MAX) begin
                    res.status = refbp_pkg::STAT_OVERFLOW;
                end else begin
                    slot_refs[idx] = slot_refs[idx] + REF_BITS'(1);
                end
            end
            refbp_pkg::OP_PUT: begin
                if (!slot_busy[idx] || slot_refs[idx] == 0) begin
                    res.status = refbp_pkg::STAT_COUNT_ZERO;
                end else begin
                    slot_refs[idx] = slot_refs[idx] - REF_BITS'(1);
                    if (slot_refs[idx] == 0) begin
                        release_slot(int'(idx));
                        res.released = 1'b1;
                    end
                end
            end
            refbp_pkg::OP_CLEAR: begin
                // The sweep goes in ascending slot order, so the highest
                // matching slot ends up at the head of the list.
                for (int i = 0; i < POOL_SLOTS; i++) begin
                    if (slot_busy[i] && slot_chan[i] == chan) begin
                        release_slot(i);
                        res.swept = res.swept + refbp_pkg::REL_CNT_W'(1);
                    end
                end
            end
            default: begin
                res.status = refbp_pkg::STAT_NOT_ALLOCATED;
            end
        endcase
        return res;
    endfunction

    function automatic void plan_row(logic [refbp_pkg::OP_W-1:0] op,
                                     logic [refbp_pkg::IDX_W-1:0] idx,
                                     logic [refbp_pkg::CHAN_IN_W-1:0] chan, logic typed,
                                     logic [refbp_pkg::STATUS_W-1:0] status,
                                     logic [refbp_pkg::IDX_W-1:0] slot,
                                     logic released);
        t_directed_row row;
        row.op            = op;
        row.idx           = idx;
        row.chan          = chan;
        row.typed         = typed;
        row.want.status   = status;
        row.want.slot     = slot;
        row.want.released = released;
        row.want.swept    = '0;
        directed_plan.push_back(row);
    endfunction

    // Offers one request and holds it until the transfer. At the transfer the
    // expectation is queued: the typed one for table rows that carry it, the
    // predicted one otherwise. The predicted state is updated either way.
    task automatic offer(input logic [refbp_pkg::OP_W-1:0] op,
                         input logic [refbp_pkg::IDX_W-1:0] idx,
                         input logic [refbp_pkg::CHAN_IN_W-1:0] chan,
                         input logic typed = 1'b0,
                         input t_pool_result want = '0);
        t_pool_result predicted;
        i_in_valid      <= 1'b1;
        i_operation     <= op;
        i_slot_index    <= idx;
        i_owner_channel <= chan;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = pool_step(op, idx, chan);
        pending_results.push_back(typed ? want : predicted);
        // A short sender gap now and then, with junk on the payload.
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid      <= 1'b0;
            i_operation     <= refbp_pkg::OP_W'($urandom);
            i_slot_index    <= refbp_pkg::IDX_W'($urandom);
            i_owner_channel <= refbp_pkg::CHAN_IN_W'($urandom);
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    function automatic void note_mismatch(string field, longint want, longint got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $error("%s: expected %0d, actual %0d", field, want, got);
    endfunction

    initial begin : stimulus
        logic [refbp_pkg::OP_W-1:0]      op;
        logic [refbp_pkg::IDX_W-1:0]     idx;
        logic [refbp_pkg::CHAN_IN_W-1:0] chan;
        logic [refbp_pkg::CHAN_IN_W-1:0] focus [4];
        int                              live [$];
        int                              pick;

        free_head = '0;
        foreach (free_link[s]) begin
            free_link[s] = (refbp_pkg::IDX_W+1)'(s + 1);
            slot_busy[s] = 1'b0;
            slot_refs[s] = '0;
            slot_chan[s] = '0;
        end

        // Directed table. Right after reset slot 0 heads the list, so the
        // first rows can be typed in; the rest rely on the prediction.
        plan_row(refbp_pkg::OP_ALLOC, 10'h000, 8'hFF, 1'b1, refbp_pkg::STAT_OK,
                 10'h000, 1'b0);
        plan_row(refbp_pkg::OP_ALLOC, 10'h3FF, 8'h00, 1'b1, refbp_pkg::STAT_OK,
                 10'h001, 1'b0);
        plan_row(refbp_pkg::OP_GET, 10'h000, 8'h00, 1'b1, refbp_pkg::STAT_OK,
                 10'h000, 1'b0);
        plan_row(refbp_pkg::OP_PUT, 10'h000, 8'h00, 1'b1, refbp_pkg::STAT_OK,
                 10'h000, 1'b0);
        plan_row(refbp_pkg::OP_PUT, 10'h000, 8'h00, 1'b1, refbp_pkg::STAT_OK,
                 10'h000, 1'b1);
        // Put and get on a returned slot act as if its count were zero.
        plan_row(refbp_pkg::OP_PUT, 10'h000, 8'h00, 1'b1, refbp_pkg::STAT_COUNT_ZERO,
                 10'h000, 1'b0);
        plan_row(refbp_pkg::OP_GET, 10'h000, 8'h00, 1'b1, refbp_pkg::STAT_COUNT_ZERO,
                 10'h000, 1'b0);
        // Double free is flagged and leaves the list intact.
        plan_row(refbp_pkg::OP_FREE, 10'h000, 8'h00, 1'b1, refbp_pkg::STAT_NOT_ALLOCATED,
                 10'h000, 1'b0);
        plan_row(refbp_pkg::OP_FREE, 10'h001, 8'h00, 1'b1, refbp_pkg::STAT_OK,
                 10'h001, 1'b1);
        plan_row(refbp_pkg::OP_FREE, 10'h3FF, 8'hFF, 1'b1, refbp_pkg::STAT_NOT_ALLOCATED,
                 10'h3FF, 1'b0);
        plan_row(refbp_pkg::OP_GET, 10'h3FF, 8'h00, 1'b1, refbp_pkg::STAT_COUNT_ZERO,
                 10'h3FF, 1'b0);
        plan_row(refbp_pkg::OP_PUT, 10'h3FF, 8'h00, 1'b1, refbp_pkg::STAT_COUNT_ZERO,
                 10'h3FF, 1'b0);
        plan_row(OP_RESERVED_FIRST, 10'h2AA, 8'h55, 1'b1, refbp_pkg::STAT_NOT_ALLOCATED,
                 10'h2AA, 1'b0);
        plan_row(OP_RESERVED_LAST, 10'h155, 8'hAA, 1'b1, refbp_pkg::STAT_NOT_ALLOCATED,
                 10'h155, 1'b0);
        plan_row(refbp_pkg::OP_CLEAR, 10'h000, 8'hFF, 1'b1, refbp_pkg::STAT_OK,
                 10'h000, 1'b0);
        plan_row(refbp_pkg::OP_ALLOC, 10'h000, 8'hAA, 1'b0, refbp_pkg::STAT_OK, '0, 1'b0);
        plan_row(refbp_pkg::OP_ALLOC, 10'h000, 8'hAA, 1'b0, refbp_pkg::STAT_OK, '0, 1'b0);
        plan_row(refbp_pkg::OP_ALLOC, 10'h000, 8'h55, 1'b0, refbp_pkg::STAT_OK, '0, 1'b0);
        plan_row(refbp_pkg::OP_GET, 10'h000, 8'hAA, 1'b0, refbp_pkg::STAT_OK, '0, 1'b0);
        plan_row(refbp_pkg::OP_CLEAR, 10'h000, 8'hAA, 1'b0, refbp_pkg::STAT_OK, '0, 1'b0);
        plan_row(refbp_pkg::OP_CLEAR, 10'h000, 8'hAA, 1'b0, refbp_pkg::STAT_OK, '0, 1'b0);
        plan_row(refbp_pkg::OP_PUT, 10'h002, 8'h00, 1'b0, refbp_pkg::STAT_OK, '0, 1'b0);
        plan_row(refbp_pkg::OP_ALLOC, 10'h000, 8'hFF, 1'b0, refbp_pkg::STAT_OK, '0, 1'b0);
        plan_row(refbp_pkg::OP_CLEAR, 10'h000, 8'hFF, 1'b0, refbp_pkg::STAT_OK, '0, 1'b0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_plan[r])
            offer(directed_plan[r].op, directed_plan[r].idx, directed_plan[r].chan,
                  directed_plan[r].typed, directed_plan[r].want);

        // Empty the free list among a few channels, ask two more times than it can
        // give, then let clear-channel sweeps hand everything back.
        focus[0] = 8'h00;
        focus[1] = 8'hFF;
        focus[2] = refbp_pkg::CHAN_IN_W'($urandom);
        focus[3] = refbp_pkg::CHAN_IN_W'($urandom);
        while (free_head != POOL_SLOTS)
            offer(refbp_pkg::OP_ALLOC, refbp_pkg::IDX_W'($urandom),
                  focus[$urandom_range(0, 3)]);
        repeat (2)
            offer(refbp_pkg::OP_ALLOC, refbp_pkg::IDX_W'($urandom),
                  focus[$urandom_range(0, 3)]);
        foreach (focus[c])
            offer(refbp_pkg::OP_CLEAR, refbp_pkg::IDX_W'($urandom), focus[c]);

        // Random traffic. Most free, get and put requests hit a slot in use;
        // the rest hit any slot. The tail runs without idling.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            quiet = (n >= RANDOM_ITEMS - QUIET_ITEMS);
            live.delete();
            foreach (slot_busy[s])
                if (slot_busy[s]) live.push_back(s);
            if ($urandom_range(0, 3) != 0)
                chan = focus[$urandom_range(0, 3)];
            else
                chan = refbp_pkg::CHAN_IN_W'($urandom);
            if (live.size() != 0 && $urandom_range(0, 7) != 0)
                idx = refbp_pkg::IDX_W'(live[$urandom_range(0, live.size() - 1)]);
            else
                idx = refbp_pkg::IDX_W'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 32)
                op = refbp_pkg::OP_ALLOC;
            else if (pick < 52)
                op = refbp_pkg::OP_GET;
            else if (pick < 78)
                op = refbp_pkg::OP_PUT;
            else if (pick < 93)
                op = refbp_pkg::OP_FREE;
            else if (pick < 97)
                op = refbp_pkg::OP_CLEAR;
            else
                op = refbp_pkg::OP_W'($urandom_range(OP_RESERVED_FIRST, OP_RESERVED_LAST));
            offer(op, idx, chan);
        end

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("[refcounted_buffer_pool] OK");
        else
            $display("[refcounted_buffer_pool] ERROR");
        $finish;
    end

    // Receiver: checks each result transfer against the oldest expectation and
    // decides the ready for the next cycle. After a set number of results it
    // holds off for a long stretch, so the pool fills up and stalls its input.
    always @(posedge i_clk) begin : receiver
        t_pool_result want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $error("result transfer with no request outstanding");
                end else begin
                    want = pending_results.pop_front();
                    if (o_status !== want.status)
                        note_mismatch("status", want.status, o_status);
                    if (o_granted_slot !== want.slot)
                        note_mismatch("granted_slot", want.slot, o_granted_slot);
                    if (o_slot_released !== want.released)
                        note_mismatch("slot_released", want.released, o_slot_released);
                    if (o_released_count !== want.swept)
                        note_mismatch("released_count", want.swept, o_released_count);
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (!hold_done && results_seen >= HOLD_OFF_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_OFF_CYCLES - 1;
                i_out_ready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 2);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[refcounted_buffer_pool] ERROR");
            $finish;
        end
    end

endmodule
